// ----- src/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// Comment stripper package
// Shared types and character constants for the comment stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

  localparam int CHAR_BITS = 16;

  // Output queue geometry.
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam logic [CHAR_BITS-1:0] CH_STAR  = CHAR_BITS'('h2A);
  localparam logic [CHAR_BITS-1:0] CH_SLASH = CHAR_BITS'('h2F);
  localparam logic [CHAR_BITS-1:0] CH_CR    = CHAR_BITS'('h0D);
  localparam logic [CHAR_BITS-1:0] CH_LF    = CHAR_BITS'('h0A);
  localparam logic [CHAR_BITS-1:0] CH_BSL   = CHAR_BITS'('h5C);
  localparam logic [CHAR_BITS-1:0] CH_DQ    = CHAR_BITS'('h22);
  localparam logic [CHAR_BITS-1:0] CH_SQ    = CHAR_BITS'('h27);
  localparam logic [CHAR_BITS-1:0] CH_SP    = CHAR_BITS'('h20);

  // Scanner state carried from one character to the next.
  typedef struct packed {
    logic [CHAR_BITS-1:0] held_char;
    logic                 held_valid;
    logic [CHAR_BITS-1:0] quote_char;
    logic                 in_quote;
    logic                 escape_pending;
    logic                 in_line_comment;
    logic                 in_block_comment;
    logic                 newline_emitted;
  } scs_state_t;

  // Up to two output characters produced by one input beat.
  typedef struct packed {
    logic [1:0]           cnt;
    logic [CHAR_BITS-1:0] c0;
    logic [CHAR_BITS-1:0] c1;
  } scs_emit_t;

  localparam scs_state_t STATE_RESET = '{
    held_char:        '0,
    held_valid:       1'b0,
    quote_char:       CH_SP,
    in_quote:         1'b0,
    escape_pending:   1'b0,
    in_line_comment:  1'b0,
    in_block_comment: 1'b0,
    newline_emitted:  1'b0
  };

endpackage

`default_nettype wire

// ----- src/scs_core.sv -----
// ----------------------------------------------------------------------------
// Comment stripper scan logic
// Computes the next scanner state and the emitted characters for one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_core (
  input  wire scs_pkg::scs_state_t            st,
  input  wire logic [scs_pkg::CHAR_BITS-1:0] c,
  input  wire logic                          is_last,
  output scs_pkg::scs_state_t                st_nxt,
  output scs_pkg::scs_emit_t                 emit
);

  typedef struct packed {
    scs_pkg::scs_state_t      st;
    logic                     took;
    logic [1:0]               n;
    logic [scs_pkg::CHAR_BITS-1:0] e0;
    logic [scs_pkg::CHAR_BITS-1:0] e1;
  } handle_res_t;

  // One character with an optional lookahead character.
  function automatic handle_res_t handle(
    input scs_pkg::scs_state_t            s,
    input logic [scs_pkg::CHAR_BITS-1:0] ch,
    input logic                          has_next,
    input logic [scs_pkg::CHAR_BITS-1:0] nx
  );
    handle_res_t r;
    logic        eol;
    logic        nx_lf;
    r      = '0;
    r.st   = s;
    eol    = (ch == scs_pkg::CH_CR) || (ch == scs_pkg::CH_LF);
    nx_lf  = has_next && (nx == scs_pkg::CH_LF);
    if (s.in_block_comment) begin
      if (ch == scs_pkg::CH_STAR && has_next && nx == scs_pkg::CH_SLASH) begin
        if (!s.newline_emitted) begin
          r.n  = 2'd1;
          r.e0 = scs_pkg::CH_SP;
        end
        r.st.in_block_comment = 1'b0;
        r.took = 1'b1;
      end else if (eol) begin
        r.n  = 2'd1;
        r.e0 = ch;
        r.st.newline_emitted = 1'b1;
        if (nx_lf) begin
          r.n    = 2'd2;
          r.e1   = scs_pkg::CH_LF;
          r.took = 1'b1;
        end
      end
    end else if (s.in_line_comment) begin
      if (eol) begin
        r.n  = 2'd1;
        r.e0 = ch;
        r.st.in_line_comment = 1'b0;
        if (nx_lf) begin
          r.n    = 2'd2;
          r.e1   = scs_pkg::CH_LF;
          r.took = 1'b1;
        end
      end
    end else if (s.in_quote) begin
      r.n  = 2'd1;
      r.e0 = ch;
      if (s.escape_pending) begin
        r.st.escape_pending = 1'b0;
      end else if (ch == scs_pkg::CH_BSL) begin
        r.st.escape_pending = 1'b1;
      end else if (ch == s.quote_char) begin
        r.st.in_quote = 1'b0;
      end
    end else if (ch == scs_pkg::CH_SLASH && has_next) begin
      if (nx == scs_pkg::CH_SLASH) begin
        r.st.in_line_comment = 1'b1;
        r.took = 1'b1;
      end else if (nx == scs_pkg::CH_STAR) begin
        r.st.newline_emitted  = 1'b0;
        r.st.in_block_comment = 1'b1;
        r.took = 1'b1;
      end else begin
        r.n  = 2'd1;
        r.e0 = ch;
      end
    end else if (ch == scs_pkg::CH_DQ || ch == scs_pkg::CH_SQ) begin
      r.n  = 2'd1;
      r.e0 = ch;
      r.st.in_quote   = 1'b1;
      r.st.quote_char = ch;
    end else begin
      r.n  = 2'd1;
      r.e0 = ch;
    end
    return r;
  endfunction

  handle_res_t         h1;
  handle_res_t         h2;
  scs_pkg::scs_state_t s1;

  always_comb begin
    h1 = '0;
    h2 = '0;
    if (st.held_valid) begin
      h1 = handle(st, st.held_char, 1'b1, c);
      s1 = h1.st;
      s1.held_char  = c;
      s1.held_valid = !h1.took;
    end else begin
      s1 = st;
      s1.held_char  = c;
      s1.held_valid = 1'b1;
    end

    emit.cnt = h1.n;
    emit.c0  = h1.e0;
    emit.c1  = h1.e1;
    st_nxt   = s1;

    if (is_last) begin
      // The held character, if any, is the new one; it has no lookahead.
      if (s1.held_valid) begin
        h2 = handle(s1, c, 1'b0, '0);
      end
      // A handle that takes a lookahead never runs a second time, so at most
      // one of the two handles yields two characters.
      if (h1.n == 2'd0) begin
        emit.cnt = h2.n;
        emit.c0  = h2.e0;
      end else if (h2.n != 2'd0) begin
        emit.cnt = 2'd2;
        emit.c1  = h2.e0;
      end
      st_nxt = scs_pkg::STATE_RESET;
    end
  end

endmodule

`default_nettype wire

// ----- src/scs_outq.sv -----
// ----------------------------------------------------------------------------
// Comment stripper output queue
// Small queue that takes up to two characters per cycle while it has room for two and sends one unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_outq (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire logic                          push,
  input  wire scs_pkg::scs_emit_t            push_data,
  output logic                               almost_full,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [scs_pkg::CHAR_BITS-1:0]      out_char,
  output logic                               out_run_last
);

  typedef struct packed {
    logic [scs_pkg::CHAR_BITS-1:0] ch;
    logic                          last;
  } qent_t;

  qent_t                          mem [scs_pkg::QDEPTH];
  logic [scs_pkg::QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [scs_pkg::QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [scs_pkg::QCNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [scs_pkg::QPTR_BITS-1:0]  wr_ptr_p1;
  logic [1:0]                     push_n;
  logic                           pop;

  assign push_n      = push ? push_data.cnt : 2'd0;
  assign pop         = out_valid && !out_stall;
  assign wr_ptr_p1   = scs_pkg::QPTR_BITS'(wr_ptr_r + 1'b1);
  // Room for two more entries is needed before a beat is taken.
  assign almost_full = cnt_r > scs_pkg::QCNT_BITS'(scs_pkg::QDEPTH - 2);
  assign out_valid   = cnt_r != '0;
  assign out_char    = mem[rd_ptr_r].ch;
  assign out_run_last = mem[rd_ptr_r].last;

  always_comb begin
    wr_ptr_nxt = scs_pkg::QPTR_BITS'(wr_ptr_r + push_n);
    rd_ptr_nxt = scs_pkg::QPTR_BITS'(rd_ptr_r + pop);
    cnt_nxt    = scs_pkg::QCNT_BITS'(cnt_r + push_n - pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= '{ch: push_data.c0, last: push_n == 2'd1};
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_p1] <= '{ch: push_data.c1, last: 1'b1};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= scs_pkg::QCNT_BITS'(scs_pkg::QDEPTH))
    else $error("output queue count exceeds its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !almost_full)
    else $error("push while output queue lacks room for two entries");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty output queue with unequal pointers");

endmodule

`default_nettype wire

// ----- src/source_comment_stripper.sv -----
// ----------------------------------------------------------------------------
// Source comment stripper
// Removes line and block comments from a character stream, keeping lines.
// ----------------------------------------------------------------------------
// Output: a result enters the registered output queue with the beat that
//   resolves it; one character is held for lookahead, so most results come
//   one beat late. Throughput: one input beat per cycle while beats make at most
//   one result and the output does not stall; the single output port sends
//   one beat per cycle unless stalled; a four-entry queue absorbs the excess.
// Reset: synchronous, active low; clears the scanner state and the queue.
`default_nettype none

module source_comment_stripper (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [scs_pkg::CHAR_BITS-1:0] in_char,
  input  wire logic                          in_is_last,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [scs_pkg::CHAR_BITS-1:0]      out_char,
  output logic                               out_run_last
);

  // Scanner state: held lookahead character, quote tracking and comment flags.
  // It advances exactly once for each accepted input beat.
  scs_pkg::scs_state_t st_r;
  scs_pkg::scs_state_t st_nxt;
  scs_pkg::scs_emit_t  emit;
  logic                in_acc;
  logic                q_almost_full;

  // The input side stalls only when the queue might not hold two more
  // characters; it does not wait for earlier results to leave.
  assign in_stall = q_almost_full;
  assign in_acc   = in_valid && !in_stall;

  // The scan logic works directly on the accepted beat and the stored state.
  // At the end of text it flushes the held character and returns to reset.
  scs_core u_core (
    .st      (st_r),
    .c       (in_char),
    .is_last (in_is_last),
    .st_nxt  (st_nxt),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= scs_pkg::STATE_RESET;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // Results are registered in the queue; each beat pushes zero, one or two
  // characters, and the last of them carries the run-last flag.
  scs_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_acc),
    .push_data    (emit),
    .almost_full  (q_almost_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

  // The end of text leaves nothing held and every mode closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_is_last) |=>
      (!st_r.held_valid && !st_r.in_quote && !st_r.in_line_comment &&
       !st_r.in_block_comment))
    else $error("state not cleared after end of text");

  // The scanner is in at most one of its modes at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({st_r.in_quote, st_r.in_line_comment, st_r.in_block_comment}))
    else $error("scanner in more than one mode");

  // An escape is only pending inside a quoted string.
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r.escape_pending |-> st_r.in_quote)
    else $error("escape pending outside a quoted string");

  // Once a beat has been taken in the middle of a text, a character is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_is_last && !st_r.held_valid) |=> st_r.held_valid)
    else $error("character not held after a first beat");

endmodule

`default_nettype wire
